@@ sv/iolh_pkg.sv @@
// iolh_pkg: shared types, codes and helpers for the latency histogram
// no dependencies
`timescale 1ns / 1ps
package iolh_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int HIST_BUCKETS  = 32;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int BKT_W         = 5;
    localparam int LAT_W         = 55;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        OP_ISSUE    = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_READ     = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_COUNTED   = 3'd2,
        ST_UNMATCHED = 3'd3,
        ST_READ      = 3'd4
    } status_t;

    // command from the front part to the back part
    typedef struct packed {
        opcode_t          op;
        logic [63:0]      key;
        logic [63:0]      time_ns;
        logic [BKT_W-1:0] read_index;
    } cmd_t;

    typedef struct packed {
        status_t          status;
        logic [BKT_W-1:0] bucket;
        logic [LAT_W-1:0] latency_us;
        logic [63:0]      bucket_count;
    } result_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN,
        BK_ACCESS,
        BK_RDWAIT,
        BK_DIV,
        BK_LOG,
        BK_CNTRD,
        BK_CNTWR,
        BK_OUT
    } back_state_t;

    // floor log2 capped at 31, zero for 0 and 1
    function automatic logic [BKT_W-1:0] log2_bucket(input logic [LAT_W-1:0] v);
        logic [BKT_W-1:0] b;
        b = '0;
        if (|v[LAT_W-1:31]) begin
            b = 5'd31;
        end else begin
            for (int i = 1; i < 31; i++) begin
                if (v[i]) begin
                    b = BKT_W'(i);
                end
            end
        end
        return b;
    endfunction

endpackage

@@ sv/io_latency_log2_histogram.sv @@
// io_latency_log2_histogram: top level, front queue plus back engine
// depends on iolh_pkg, iolh_front, iolh_back
//
// channel  dir  payload
// s_       in   opcode, device_id, sector_low, time_ns, read_index
// m_       out  status, bucket, latency_us, bucket_count
//
// an issue or a completion first scans the 1024-entry pending table at one
// entry per cycle; a matched completion then divides its latency by 1000
// and updates the bucket and counter. a read goes straight to the counter;
// an unused opcode is dropped. after reset a pass over all 1024 entries
// clears the valid bits; counters clear at once.
// a two-deep queue lets the input side fill while the back part works or
// while a result waits on m_tready.
`timescale 1ns / 1ps
module io_latency_log2_histogram (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[1:0], device_id[33:2], sector_low[65:34], time_ns[129:66],
    // read_index[134:130], zero pad[135]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], bucket[7:3], latency_us[62:8], bucket_count[126:63],
    // zero pad[127]
    output logic [127:0] m_tdata
);
    import iolh_pkg::*;

    logic    q_valid;
    logic    q_pop;
    cmd_t    q_cmd;
    result_t res;

    iolh_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_cmd   (q_cmd)
    );

    iolh_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_cmd   (q_cmd),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_res   (res)
    );

    assign m_tdata = {1'b0, res.bucket_count, res.latency_us, res.bucket, res.status};

endmodule

@@ sv/iolh_front.sv @@
// iolh_front: accepts items, drops unused opcodes, queues commands
// depends on iolh_pkg
`timescale 1ns / 1ps
module iolh_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [135:0]  s_tdata,
    output logic          q_valid,
    input  logic          q_pop,
    output iolh_pkg::cmd_t q_cmd
);
    import iolh_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   fill_reg, fill_next;
    cmd_t             in_cmd;
    logic             push;

    // classify the incoming item
    always_comb begin
        in_cmd.op         = opcode_t'(s_tdata[1:0]);
        in_cmd.key        = {s_tdata[33:2], s_tdata[65:34]};
        in_cmd.time_ns    = s_tdata[129:66];
        in_cmd.read_index = s_tdata[134:130];
    end

    assign s_tready = (fill_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready && (in_cmd.op != OP_NONE);
    assign q_valid  = (fill_reg != '0);
    assign q_cmd    = queue_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // queue never overflows or underflows
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue overfill");
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid) else $error("pop from empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg)) else $error("pointer skew");

endmodule

@@ sv/iolh_back.sv @@
// iolh_back: pending table scan, latency division, histogram update
// depends on iolh_pkg
`timescale 1ns / 1ps
module iolh_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_pop,
    input  iolh_pkg::cmd_t  q_cmd,
    output logic            m_tvalid,
    input  logic            m_tready,
    output iolh_pkg::result_t m_res
);
    import iolh_pkg::*;

    localparam logic [9:0]  DIV_CONST = 10'd1000;
    // 2^36 / 1000 rounded up, exact quotient for dividends below 2^26
    localparam logic [26:0] DIV_MAGIC = 27'd68719477;

    // pending table storage, keys, start times and valid bits in memories
    logic [63:0]        key_mem   [TABLE_ENTRIES];
    logic [63:0]        start_mem [TABLE_ENTRIES];
    logic               valid_mem [TABLE_ENTRIES];
    logic [63:0]        counts_reg [HIST_BUCKETS];

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic               hit_reg, hit_next;
    logic [SLOT_W-1:0]  hit_slot_reg, hit_slot_next;
    logic               free_reg, free_next;
    logic [SLOT_W-1:0]  free_slot_reg, free_slot_next;
    logic [63:0]        key_rd_reg;
    logic [63:0]        start_rd_reg;
    logic               valid_rd_reg;
    logic [SLOT_W-1:0]  rd_addr;
    logic               rd_prev_reg;
    logic [SLOT_W-1:0]  rd_prev_addr_reg;
    logic               mem_we;
    logic               valid_we;
    logic               valid_wdata;
    logic [SLOT_W-1:0]  wr_addr;
    logic [63:0]        quot_reg, quot_next;
    logic [1:0]         dstep_reg, dstep_next;
    logic [9:0]         rem_reg, rem_next;
    logic [25:0]        div_val;
    logic [52:0]        div_prod;
    logic [15:0]        div_q16;
    logic [9:0]         div_rem;
    logic [BKT_W-1:0]   bkt_reg, bkt_next;
    logic [63:0]        cnt_reg, cnt_next;
    logic               cnt_we;
    result_t            res_reg, res_next;
    result_t            out_res_reg;
    logic               out_load;
    logic               out_valid_reg, out_valid_next;

    // scan reads one entry per cycle, access reads the found slot
    assign rd_addr = (state_reg == BK_SCAN) ? idx_reg : hit_slot_next;

    always_ff @(posedge aclk) begin
        key_rd_reg   <= key_mem[rd_addr];
        start_rd_reg <= start_mem[rd_addr];
        valid_rd_reg <= valid_mem[rd_addr];
        if (mem_we) begin
            key_mem[wr_addr]   <= cmd_reg.key;
            start_mem[wr_addr] <= cmd_reg.time_ns;
        end
        if (valid_we) begin
            valid_mem[wr_addr] <= valid_wdata;
        end
    end

    // remember which slot the registered read data belongs to
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_prev_reg <= 1'b0;
        end else begin
            rd_prev_reg <= (state_reg == BK_SCAN);
        end
        rd_prev_addr_reg <= rd_addr;
    end

    // division by 1000, 16 dividend bits per cycle by reciprocal multiply
    assign div_val  = {rem_reg, quot_reg[63:48]};
    assign div_prod = 53'(div_val) * 53'(DIV_MAGIC);
    assign div_q16  = div_prod[51:36];
    assign div_rem  = div_val[9:0] - (div_q16[9:0] * DIV_CONST);

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        dstep_next     = dstep_reg;
        bkt_next       = bkt_reg;
        cnt_next       = cnt_reg;
        cnt_we         = 1'b0;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        valid_we       = 1'b0;
        valid_wdata    = 1'b0;
        wr_addr        = hit_slot_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        // check the entry read last cycle for a key match and a free slot
        if (rd_prev_reg) begin
            if (!hit_reg && valid_rd_reg && key_rd_reg == cmd_reg.key) begin
                hit_next      = 1'b1;
                hit_slot_next = rd_prev_addr_reg;
            end
            if (!free_reg && !valid_rd_reg) begin
                free_next      = 1'b1;
                free_slot_next = rd_prev_addr_reg;
            end
        end
        unique case (state_reg)
            BK_CLEAR: begin
                // clear one valid bit per cycle after reset
                valid_we = 1'b1;
                wr_addr  = idx_reg;
                if (idx_reg == SLOT_W'(TABLE_ENTRIES - 1)) begin
                    state_next = BK_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    cmd_next  = q_cmd;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                    if (q_cmd.op == OP_READ) begin
                        state_next = BK_CNTRD;
                    end else begin
                        state_next = BK_SCAN;
                    end
                end
            end
            BK_SCAN: begin
                if (idx_reg == SLOT_W'(TABLE_ENTRIES - 1)) begin
                    state_next = BK_ACCESS;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            BK_ACCESS: begin
                // the last check lands this cycle, hit and free are final
                if (cmd_reg.op == OP_ISSUE) begin
                    if (hit_next || free_next) begin
                        mem_we      = 1'b1;
                        valid_we    = 1'b1;
                        valid_wdata = 1'b1;
                        wr_addr     = hit_next ? hit_slot_next : free_slot_next;
                        res_next = '{status: ST_STORED, bucket: '0,
                                     latency_us: '0, bucket_count: '0};
                    end else begin
                        res_next = '{status: ST_DROPPED, bucket: '0,
                                     latency_us: '0, bucket_count: '0};
                    end
                    state_next = BK_OUT;
                end else if (hit_next) begin
                    state_next = BK_RDWAIT;
                end else begin
                    res_next = '{status: ST_UNMATCHED, bucket: '0,
                                 latency_us: '0, bucket_count: '0};
                    state_next = BK_OUT;
                end
            end
            BK_RDWAIT: begin
                // start time of the hit slot is now registered, free the slot
                state_next = BK_DIV;
                valid_we   = 1'b1;
                quot_next  = cmd_reg.time_ns - start_rd_reg;
                rem_next   = '0;
                dstep_next = '0;
            end
            BK_DIV: begin
                // quotient digits shift in as dividend digits shift out
                rem_next   = div_rem;
                quot_next  = {quot_reg[47:0], div_q16};
                dstep_next = dstep_reg + 1'b1;
                if (dstep_reg == 2'd3) begin
                    state_next = BK_LOG;
                end
            end
            BK_LOG: begin
                bkt_next   = log2_bucket(quot_reg[LAT_W-1:0]);
                state_next = BK_CNTRD;
            end
            BK_CNTRD: begin
                if (cmd_reg.op == OP_READ) begin
                    res_next = '{status: ST_READ, bucket: cmd_reg.read_index,
                                 latency_us: '0,
                                 bucket_count: counts_reg[cmd_reg.read_index]};
                    state_next = BK_OUT;
                end else begin
                    cnt_next   = counts_reg[bkt_reg] + 64'd1;
                    state_next = BK_CNTWR;
                end
            end
            BK_CNTWR: begin
                cnt_we   = 1'b1;
                res_next = '{status: ST_COUNTED, bucket: bkt_reg,
                             latency_us: quot_reg[LAT_W-1:0], bucket_count: cnt_reg};
                state_next = BK_OUT;
            end
            BK_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_load       = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_CLEAR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HIST_BUCKETS; i++) begin
                counts_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cnt_we) begin
                counts_reg[bkt_reg] <= cnt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        hit_reg       <= hit_next;
        hit_slot_reg  <= hit_slot_next;
        free_reg      <= free_next;
        free_slot_reg <= free_slot_next;
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        dstep_reg     <= dstep_next;
        bkt_reg       <= bkt_next;
        cnt_reg       <= cnt_next;
        res_reg       <= res_next;
        if (out_load) begin
            out_res_reg <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_res    = out_res_reg;

    // a new command is only taken when idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == BK_IDLE)) else $error("pop while busy");
    // counter write only after a completion lookup
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_we |-> (cmd_reg.op == OP_COMPLETE)) else $error("stray counter write");
    // a completed lookup frees its slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_RDWAIT) |-> (valid_we && !valid_wdata))
        else $error("slot not freed");
    // a stored entry is always marked valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (valid_we && valid_wdata)) else $error("entry stored invalid");
    // a waiting result item holds steady
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_res_reg)))
        else $error("result changed while waiting");

endmodule
